/* hdl/rsu_pkg.sv */
// ----------------------------------------------------------------------------
// rsu_pkg
// Shared types, register map and mod-26 helpers for the rotor stepping unit.
// ----------------------------------------------------------------------------
package rsu_pkg;

  localparam int unsigned POS_W   = 5;
  localparam int unsigned IDX_W   = 15;
  localparam int unsigned ALPHA   = 26;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned IN_TW   = 24;
  localparam int unsigned OUT_TW  = 32;

  localparam logic [POS_W-1:0] POS_MAX = POS_W'(ALPHA - 1);

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_FWD  = 2'd1,
    CMD_BACK = 2'd2,
    CMD_ODO  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_MID_NOTCH_A   = 3'd0,
    REG_MID_NOTCH_B   = 3'd1,
    REG_RGT_NOTCH_A   = 3'd2,
    REG_RGT_NOTCH_B   = 3'd3,
    REG_LEFT_RING     = 3'd4,
    REG_MID_RING      = 3'd5,
    REG_RGT_RING      = 3'd6,
    REG_NONE          = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [POS_W-1:0] l;
    logic [POS_W-1:0] m;
    logic [POS_W-1:0] r;
  } pos_t;

  typedef struct packed {
    pos_t pos;
    logic wrapped;
  } step_beat_t;

  typedef struct packed {
    logic [POS_W-1:0] mid_notch_a;
    logic [POS_W-1:0] mid_notch_b;
    logic [POS_W-1:0] rgt_notch_a;
    logic [POS_W-1:0] rgt_notch_b;
    logic [POS_W-1:0] left_ring;
    logic [POS_W-1:0] mid_ring;
    logic [POS_W-1:0] rgt_ring;
  } cfg_t;

  function automatic logic [POS_W-1:0] fold26(input logic [POS_W-1:0] v);
    return (v >= POS_W'(ALPHA)) ? v - POS_W'(ALPHA) : v;
  endfunction

  function automatic logic [POS_W-1:0] up26(input logic [POS_W-1:0] v);
    return (v >= POS_MAX) ? '0 : v + POS_W'(1);
  endfunction

  function automatic logic [POS_W-1:0] down26(input logic [POS_W-1:0] v);
    return (v == '0) ? POS_MAX : v - POS_W'(1);
  endfunction

  // a is already in range, b may be 26..31
  function automatic logic [POS_W-1:0] sub26(input logic [POS_W-1:0] a,
                                             input logic [POS_W-1:0] b);
    logic [POS_W-1:0] bf;
    bf = fold26(b);
    return (a >= bf) ? a - bf : a + POS_W'(ALPHA) - bf;
  endfunction

endpackage

/* hdl/rsu_cfg.sv */
// ----------------------------------------------------------------------------
// rsu_cfg
// APB-style register file holding notch positions and ring settings.
// ----------------------------------------------------------------------------
module rsu_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rsu_pkg::ADDR_W-1:0]  paddr,
  input  logic [rsu_pkg::DATA_W-1:0]  pwdata,
  output logic [rsu_pkg::DATA_W-1:0]  prdata,
  output rsu_pkg::cfg_t               cfg
);
  import rsu_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  reg_idx_t   idx;
  logic [POS_W-1:0] wval;

  assign wr_en = psel && penable && pwrite;
  assign idx   = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wval  = pwdata[POS_W-1:0];
  assign cfg   = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mid_notch_a <= POS_W'(16);
      cfg_r.mid_notch_b <= POS_W'(31);
      cfg_r.rgt_notch_a <= POS_W'(21);
      cfg_r.rgt_notch_b <= POS_W'(31);
      cfg_r.left_ring   <= '0;
      cfg_r.mid_ring    <= '0;
      cfg_r.rgt_ring    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MID_NOTCH_A: cfg_r.mid_notch_a <= wval;
        REG_MID_NOTCH_B: cfg_r.mid_notch_b <= wval;
        REG_RGT_NOTCH_A: cfg_r.rgt_notch_a <= wval;
        REG_RGT_NOTCH_B: cfg_r.rgt_notch_b <= wval;
        REG_LEFT_RING:   cfg_r.left_ring   <= wval;
        REG_MID_RING:    cfg_r.mid_ring    <= wval;
        REG_RGT_RING:    cfg_r.rgt_ring    <= wval;
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_MID_NOTCH_A: prdata = DATA_W'(cfg_r.mid_notch_a);
      REG_MID_NOTCH_B: prdata = DATA_W'(cfg_r.mid_notch_b);
      REG_RGT_NOTCH_A: prdata = DATA_W'(cfg_r.rgt_notch_a);
      REG_RGT_NOTCH_B: prdata = DATA_W'(cfg_r.rgt_notch_b);
      REG_LEFT_RING:   prdata = DATA_W'(cfg_r.left_ring);
      REG_MID_RING:    prdata = DATA_W'(cfg_r.mid_ring);
      REG_RGT_RING:    prdata = DATA_W'(cfg_r.rgt_ring);
      default:         prdata = '0;
    endcase
  end

endmodule

/* hdl/rsu_step.sv */
// ----------------------------------------------------------------------------
// rsu_step
// Rotor position state and command decode: load, double-step forward,
// inverse step and odometer increment. Registers the new positions.
// ----------------------------------------------------------------------------
module rsu_step (
  input  logic                      clk,
  input  logic                      rst_n,
  input  rsu_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  rsu_pkg::cmd_t             cmd,
  input  rsu_pkg::pos_t             load_pos,
  output logic                      s_valid,
  input  logic                      s_ready,
  output rsu_pkg::step_beat_t       s_beat
);
  import rsu_pkg::*;

  pos_t       pos_r, pos_nxt;
  step_beat_t beat_r;
  logic       vld_r;
  logic       accept;
  logic       wrap_nxt;

  function automatic logic mid_notch(input cfg_t c, input logic [POS_W-1:0] p);
    return (p == c.mid_notch_a) || (p == c.mid_notch_b);
  endfunction

  function automatic logic rgt_notch(input cfg_t c, input logic [POS_W-1:0] p);
    return (p == c.rgt_notch_a) || (p == c.rgt_notch_b);
  endfunction

  assign in_ready = !vld_r || s_ready;
  assign accept   = in_valid && in_ready;
  assign s_valid  = vld_r;
  assign s_beat   = beat_r;

  always_comb begin
    logic left_turn;
    logic mid_turn;
    pos_nxt   = pos_r;
    wrap_nxt  = 1'b0;
    left_turn = 1'b0;
    mid_turn  = 1'b0;
    case (cmd)
      CMD_LOAD: begin
        pos_nxt.l = fold26(load_pos.l);
        pos_nxt.m = fold26(load_pos.m);
        pos_nxt.r = fold26(load_pos.r);
      end
      CMD_FWD: begin
        // double step: middle at its notch drags itself and the left rotor
        if (mid_notch(cfg, pos_r.m)) begin
          pos_nxt.l = up26(pos_r.l);
          pos_nxt.m = up26(pos_r.m);
        end else if (rgt_notch(cfg, pos_r.r)) begin
          pos_nxt.m = up26(pos_r.m);
        end
        pos_nxt.r = up26(pos_r.r);
      end
      CMD_BACK: begin
        mid_turn  = rgt_notch(cfg, down26(pos_r.r));
        left_turn = mid_notch(cfg, down26(pos_r.m));
        if (left_turn) pos_nxt.l = down26(pos_r.l);
        if (mid_turn || left_turn) pos_nxt.m = down26(pos_r.m);
        pos_nxt.r = down26(pos_r.r);
      end
      default: begin
        pos_nxt.r = up26(pos_r.r);
        if (pos_r.r == POS_MAX) begin
          pos_nxt.m = up26(pos_r.m);
          if (pos_r.m == POS_MAX) begin
            pos_nxt.l = up26(pos_r.l);
            wrap_nxt  = (pos_r.l == POS_MAX);
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      vld_r <= 1'b0;
    end else begin
      if (accept) pos_r <= pos_nxt;
      if (in_ready) vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      beat_r.pos     <= pos_nxt;
      beat_r.wrapped <= wrap_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r.l <= POS_MAX) && (pos_r.m <= POS_MAX) && (pos_r.r <= POS_MAX))
    else $error("rotor position out of range");

  a_fwd_right: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd == CMD_FWD) |=> pos_r.r == up26($past(pos_r.r)))
    else $error("right rotor did not advance on forward step");

  a_beat_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> vld_r && (beat_r.pos == pos_r))
    else $error("stage beat does not match rotor state");

  a_wrap_only_odo: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (cmd != CMD_ODO) |=> !beat_r.wrapped)
    else $error("wrap flagged on non-odometer command");

endmodule

/* hdl/rsu_index.sv */
// ----------------------------------------------------------------------------
// rsu_index
// Ring adjustment and scrambler index, held in the result register.
// ----------------------------------------------------------------------------
module rsu_index (
  input  logic                           clk,
  input  logic                           rst_n,
  input  rsu_pkg::cfg_t                  cfg,
  input  logic                           s_valid,
  output logic                           s_ready,
  input  rsu_pkg::step_beat_t            s_beat,
  output logic                           out_valid,
  input  logic                           out_ready,
  output rsu_pkg::step_beat_t            out_beat,
  output logic [rsu_pkg::IDX_W-1:0]      out_index
);
  import rsu_pkg::*;

  localparam logic [IDX_W-1:0] L_MUL = IDX_W'(ALPHA * ALPHA);
  localparam logic [IDX_W-1:0] M_MUL = IDX_W'(ALPHA);

  logic             vld_r;
  step_beat_t       beat_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [POS_W-1:0] l_adj, m_adj, r_adj;

  assign s_ready   = !vld_r || out_ready;
  assign out_valid = vld_r;
  assign out_beat  = beat_r;
  assign out_index = idx_r;

  assign l_adj = sub26(s_beat.pos.l, cfg.left_ring);
  assign m_adj = sub26(s_beat.pos.m, cfg.mid_ring);
  assign r_adj = sub26(s_beat.pos.r, cfg.rgt_ring);

  // constant multiplies, max 25*676+25*26+25 = 17575 fits in 15 bits
  assign idx_nxt = IDX_W'(l_adj) * L_MUL + IDX_W'(m_adj) * M_MUL + IDX_W'(r_adj);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (s_ready) begin
      vld_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      beat_r <= s_beat;
      idx_r  <= idx_nxt;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r |-> idx_r < IDX_W'(ALPHA * ALPHA * ALPHA))
    else $error("scrambler index out of range");

  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && beat_r.wrapped |-> (beat_r.pos == '0))
    else $error("wrap flagged with nonzero positions");

  a_hold_stall: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !out_ready |=> vld_r && $stable(idx_r) && $stable(beat_r))
    else $error("result changed while stalled");

endmodule

/* hdl/rotor_stepping_unit_core.sv */
// ----------------------------------------------------------------------------
// rotor_stepping_unit_core
// Three-rotor position keeper with double stepping and scrambler index.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one command beat per accepted transfer (load, step forward,
//            step back, odometer increment) with the three load positions.
//   out_*  : exactly one result beat per command: new positions, the
//            ring-adjusted scrambler index and the odometer wrap flag.
//   cfg_*  : APB-style register port for notch positions and ring settings;
//            write only while no command is in flight.
// Each input beat passes one register stage for the rotor update and one
// for the index before its result beat. Throughput is one command per
// cycle while the receiver takes results; the rotor update feeds back
// through the position register, which sets that rate.
// A stalled receiver holds the result register; the update stage keeps
// taking beats until it too is full, then in_tready drops.
// Reset (rst_n low, synchronous) zeroes the positions, empties both
// stages and returns the registers to their default notches and rings.
// ----------------------------------------------------------------------------
module rotor_stepping_unit_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [1:0] command, [6:2] load_left, [11:7] load_middle, [16:12] load_right
  input  logic [rsu_pkg::IN_TW-1:0]      in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [4:0] left_now, [9:5] middle_now, [14:10] right_now,
  // [29:15] scrambler_index, [30] wrapped
  output logic [rsu_pkg::OUT_TW-1:0]     out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rsu_pkg::ADDR_W-1:0]     cfg_paddr,
  input  logic [rsu_pkg::DATA_W-1:0]     cfg_pwdata,
  output logic [rsu_pkg::DATA_W-1:0]     cfg_prdata,
  output logic                           cfg_pready
);
  import rsu_pkg::*;

  cfg_t             cfg;
  cmd_t             cmd;
  pos_t             load_pos;
  logic             s_valid;
  logic             s_ready;
  step_beat_t       s_beat;
  step_beat_t       out_beat;
  logic [IDX_W-1:0] out_index;

  assign cfg_pready = 1'b1;

  assign cmd        = cmd_t'(in_tdata[1:0]);
  assign load_pos.l = in_tdata[6:2];
  assign load_pos.m = in_tdata[11:7];
  assign load_pos.r = in_tdata[16:12];

  assign out_tdata = {1'b0, out_beat.wrapped, out_index,
                      out_beat.pos.r, out_beat.pos.m, out_beat.pos.l};

  rsu_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  rsu_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .cmd      (cmd),
    .load_pos (load_pos),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .s_beat   (s_beat)
  );

  rsu_index u_index (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_beat    (s_beat),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_beat  (out_beat),
    .out_index (out_index)
  );

endmodule
